>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> rtl/core/phsc_pkg.sv
// Package for the pump hysteresis safety controller: item layout, codes and
// register defaults. Depends on nothing.
`default_nettype none

package phsc_pkg;

    // Mode codes as they arrive in control_mode and as held in run_mode.
    localparam logic [1:0] MODE_INVALID = 2'd0;
    localparam logic [1:0] MODE_AUTO    = 2'd1;
    localparam logic [1:0] MODE_MANUAL  = 2'd2;

    // Stop reason codes.
    typedef enum logic [3:0] {
        R_NONE    = 4'd0,
        R_WIFI    = 4'd1,
        R_AUTH    = 4'd2,
        R_CONTROL = 4'd3,
        R_STALE   = 4'd4,
        R_SOIL    = 4'd5,
        R_MODE    = 4'd6,
        R_RUNTIME = 4'd7,
        R_MANUAL  = 4'd8,
        R_WET     = 4'd9
    } reason_t;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RUNTIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_STALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 2'd2;

    // Register reset values.
    localparam logic [31:0] MAX_RUNTIME_RST   = 32'd600000;
    localparam logic [31:0] CONTROL_STALE_RST = 32'd30000;
    localparam logic [31:0] COOLDOWN_RST      = 32'd300000;

    localparam logic [31:0] MIN_MANUAL_MS = 32'd1000;
    localparam logic [7:0]  PERCENT_MAX   = 8'd100;

    // Flag bit positions within status_flags.
    localparam int unsigned FLAG_WIFI    = 0;
    localparam int unsigned FLAG_AUTH    = 1;
    localparam int unsigned FLAG_CVALID  = 2;
    localparam int unsigned FLAG_SVALID  = 3;
    localparam int unsigned FLAG_GRANT   = 4;
    localparam int unsigned FLAG_TRUSTED = 5;

    // One input item; the last member sits in the lowest bits of tdata.
    typedef struct packed {
        logic [31:0] grant_expires_at;
        logic [31:0] unix_seconds;
        logic [7:0]  soil_percent;
        logic [31:0] now_ms;
        logic [31:0] control_received_ms;
        logic [31:0] manual_duration_ms;
        logic [6:0]  moisture_stop;
        logic [6:0]  moisture_start;
        logic [1:0]  control_mode;
        logic [5:0]  status_flags;
    } item_t;

    localparam int unsigned ITEM_W   = $bits(item_t);
    localparam int unsigned S_DATA_W = ((ITEM_W + 7) / 8) * 8;
    localparam int unsigned M_DATA_W = 8;

    // Field positions inside m_tdata.
    localparam int unsigned OUT_CHANGED = 0;
    localparam int unsigned OUT_PUMP_ON = 1;

endpackage

`default_nettype wire

>>> rtl/core/pump_hysteresis_safety_controller.sv
// Top level of the pump hysteresis safety controller.
// Depends on phsc_pkg; checked by phsc_checker through a bind.
//
// The block takes one evaluation tick per item on the s_ side and returns
// exactly one result item per tick on the m_ side. It accepts an item in every
// clock cycle while the m_ side takes results. An accepted item goes into the
// input register; the decision logic then writes the result register and the
// pump state on the same edge, and the result register drives the m_ side.
// The rate is set by that single decision stage, which reads the pump state
// left by the previous tick, so one item per cycle is sustained as long as the
// m_ side takes results. Safety checks run in priority order (wifi, auth, bad
// control, stale control, bad soil, mode change, then run time, manual length
// and wet soil) and stop the pump with their reason code; a failed check on an
// idle pump still reports the reason with changed and pump_on low. All time
// differences wrap modulo 2^32. The user must write configuration registers
// through cfg_we, cfg_index and cfg_data only while no item is in flight; the
// block itself does not enforce this.
`default_nettype none

module pump_hysteresis_safety_controller
    import phsc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit up: status_flags[5:0], control_mode[7:6],
    // moisture_start[14:8], moisture_stop[21:15], manual_duration_ms[53:22],
    // control_received_ms[85:54], now_ms[117:86], soil_percent[125:118],
    // unix_seconds[157:126], grant_expires_at[189:158], zero fill [191:190].
    input  wire logic [S_DATA_W-1:0]  s_tdata,

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata, lowest bit up: changed[0], pump_on[1], stop_reason[5:2],
    // zero fill [7:6].
    output logic [M_DATA_W-1:0]       m_tdata
);

    // Configuration registers.
    logic [31:0] max_runtime_reg;
    logic [31:0] control_stale_reg;
    logic [31:0] cooldown_reg;

    // Input register.
    logic  in_valid_reg;
    item_t in_reg;

    // Result register.
    logic    out_valid_reg;
    logic    changed_reg;
    logic    pump_on_reg;
    reason_t reason_reg;

    // Pump state.
    logic        running_reg;
    logic        stopped_before_reg;
    logic [1:0]  run_mode_reg;
    logic [31:0] run_start_reg;
    logic [31:0] last_stop_reg;
    logic [31:0] run_length_reg;

    // The decision stage fires when it holds an item and the result register
    // is free or being emptied this cycle.
    logic fire;
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_runtime_reg   <= MAX_RUNTIME_RST;
            control_stale_reg <= CONTROL_STALE_RST;
            cooldown_reg      <= COOLDOWN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_RUNTIME:   max_runtime_reg   <= cfg_data;
                CFG_CONTROL_STALE: control_stale_reg <= cfg_data;
                CFG_COOLDOWN:      cooldown_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_reg <= item_t'(s_tdata[ITEM_W-1:0]);
        end
    end

    // Decision logic.
    logic        wifi;
    logic        auth;
    logic        grant;
    logic        trusted;
    logic        ctl_ok;
    logic        stale;
    logic        soil_bad;
    logic [31:0] ctl_age;
    logic [31:0] run_age;
    logic [31:0] idle_age;
    logic        halt;
    logic        start;
    logic [1:0]  start_mode;
    reason_t     why;

    assign wifi    = in_reg.status_flags[FLAG_WIFI];
    assign auth    = in_reg.status_flags[FLAG_AUTH];
    assign grant   = in_reg.status_flags[FLAG_GRANT];
    assign trusted = in_reg.status_flags[FLAG_TRUSTED];

    assign ctl_ok = in_reg.status_flags[FLAG_CVALID]
                 && (in_reg.control_mode inside {MODE_AUTO, MODE_MANUAL})
                 && (in_reg.moisture_start < in_reg.moisture_stop)
                 && ({1'b0, in_reg.moisture_stop} <= PERCENT_MAX)
                 && (in_reg.manual_duration_ms >= MIN_MANUAL_MS)
                 && (in_reg.manual_duration_ms <= max_runtime_reg);

    assign ctl_age  = in_reg.now_ms - in_reg.control_received_ms;
    assign run_age  = in_reg.now_ms - run_start_reg;
    assign idle_age = in_reg.now_ms - last_stop_reg;
    assign stale    = ctl_age >= control_stale_reg;
    assign soil_bad = !in_reg.status_flags[FLAG_SVALID] || (in_reg.soil_percent > PERCENT_MAX);

    always_comb
    begin
        halt       = 1'b0;
        start      = 1'b0;
        start_mode = MODE_AUTO;
        why        = R_NONE;
        if (!wifi)
        begin
            halt = 1'b1;
            why  = R_WIFI;
        end
        else if (!auth)
        begin
            halt = 1'b1;
            why  = R_AUTH;
        end
        else if (!ctl_ok)
        begin
            halt = 1'b1;
            why  = R_CONTROL;
        end
        else if (stale)
        begin
            halt = 1'b1;
            why  = R_STALE;
        end
        else if (soil_bad)
        begin
            halt = 1'b1;
            why  = R_SOIL;
        end
        else if (running_reg)
        begin
            if (in_reg.control_mode != run_mode_reg)
            begin
                halt = 1'b1;
                why  = R_MODE;
            end
            else if (run_age >= max_runtime_reg)
            begin
                halt = 1'b1;
                why  = R_RUNTIME;
            end
            else if (run_mode_reg == MODE_MANUAL && run_age >= run_length_reg)
            begin
                halt = 1'b1;
                why  = R_MANUAL;
            end
            else if (run_mode_reg == MODE_AUTO
                     && in_reg.soil_percent >= {1'b0, in_reg.moisture_stop})
            begin
                halt = 1'b1;
                why  = R_WET;
            end
        end
        else if (in_reg.control_mode == MODE_MANUAL)
        begin
            // A manual start needs a trusted grant that has not expired yet;
            // wall-clock seconds compare without wrapping.
            if (grant && trusted && (in_reg.unix_seconds < in_reg.grant_expires_at))
            begin
                start      = 1'b1;
                start_mode = MODE_MANUAL;
            end
        end
        else if ((!stopped_before_reg || idle_age >= cooldown_reg)
                 && in_reg.soil_percent <= {1'b0, in_reg.moisture_start})
        begin
            start = 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            changed_reg <= halt ? running_reg : start;
            pump_on_reg <= !halt && (running_reg || start);
            reason_reg  <= why;
        end
    end

    // Pump state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg        <= 1'b0;
            stopped_before_reg <= 1'b0;
            run_mode_reg       <= MODE_INVALID;
            run_start_reg      <= '0;
            last_stop_reg      <= '0;
            run_length_reg     <= '0;
        end
        else if (fire)
        begin
            if (halt && running_reg)
            begin
                running_reg        <= 1'b0;
                stopped_before_reg <= 1'b1;
                last_stop_reg      <= in_reg.now_ms;
                run_mode_reg       <= MODE_INVALID;
                run_length_reg     <= '0;
            end
            else if (start)
            begin
                running_reg   <= 1'b1;
                run_start_reg <= in_reg.now_ms;
                run_mode_reg  <= start_mode;
                if (start_mode == MODE_MANUAL)
                begin
                    run_length_reg <= in_reg.manual_duration_ms;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, reason_reg, pump_on_reg, changed_reg};

endmodule

`default_nettype wire

>>> rtl/core/phsc_checker.sv
// Port-level checker for the pump hysteresis safety controller, bound to the
// top level. Depends on phsc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module phsc_checker
    import phsc_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata
);

    logic [3:0] reason;
    logic       changed;
    logic       pump_on;
    assign reason  = m_tdata[5:2];
    assign changed = m_tdata[OUT_CHANGED];
    assign pump_on = m_tdata[OUT_PUMP_ON];

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && m_tvalid)

    // A running pump never carries a stop reason.
    `ASSERT_IMPLY(a_on_no_reason, clk, rst_n, m_tvalid && pump_on, reason == R_NONE)

    // Only known reason codes appear.
    `ASSERT_IMPLY(a_reason_range, clk, rst_n, m_tvalid, reason <= R_WET)

    // A change without a stop reason is a start, so the pump must be on.
    `ASSERT_IMPLY(a_start_on, clk, rst_n, m_tvalid && changed && reason == R_NONE, pump_on)

endmodule

bind pump_hysteresis_safety_controller phsc_checker u_phsc_checker (.*);

`default_nettype wire
